### rtl/core/afr_pkg.sv
// afr_pkg: shared types and constants for the addressed frame receiver
// parser phase and status codes, register indexes, crc constants; no dependencies
`timescale 1ns / 1ps

package afr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ADDR   = 3'd1,
      PH_LEN    = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRC_LO = 3'd4,
      PH_CRC_HI = 3'd5,
      PH_END    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_OK       = 3'd1,
      ST_CRC_ERR  = 3'd2,
      ST_BAD_END  = 3'd3,
      ST_ZERO_LEN = 3'd4
   } status_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_OWN_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_BYTE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_END_BYTE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CRC_ENABLE  = 3'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

endpackage

### rtl/core/afr_if.sv
// afr_req_if, afr_rsp_if: valid/ready channels of the frame receiver
// depends on nothing but the clock-domain convention of the top level
`timescale 1ns / 1ps

interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic [7:0] frame_length;
   logic [2:0] frame_status;

   modport source (output valid, output payload_valid, output payload_byte,
                   output payload_index, output frame_length, output frame_status,
                   input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input payload_index, input frame_length, input frame_status,
                   output ready);
endinterface

### rtl/core/afr_crc16.sv
// afr_crc16: one-byte update of crc-16/ccitt, msb first, no reflection
// depends on afr_pkg for the polynomial
`timescale 1ns / 1ps

module afr_crc16 (
   input  logic [15:0] crc,
   input  logic [7:0]  data,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ afr_pkg::CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

### rtl/core/addressed_frame_receiver_crc16.sv
// addressed_frame_receiver_crc16: frame parser with crc-16/ccitt check
// depends on afr_pkg, afr_if (afr_req_if, afr_rsp_if) and afr_crc16
//
//   channel  | dir | handshake      | payload
//   req_ch   | in  | valid / ready  | rx_byte
//   rsp_ch   | out | valid / ready  | payload_valid, payload_byte, payload_index,
//            |     |                | frame_length, frame_status
//   csr_*    | in  | csr_we         | csr_index, csr_wdata
//
// one item per cycle unless rsp_ch holds back a result: the parser step and byte crc
// update sit between the accepted byte and the result register, loaded next cycle.
// reset is synchronous; it returns the parser to idle and empties the result register.
// the input stalls only while a result is held and rsp_ch.ready is low.
`timescale 1ns / 1ps

module addressed_frame_receiver_crc16 (
   input  logic                              clock,
   input  logic                              reset,
   afr_req_if.sink                           req_ch,
   afr_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [afr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [afr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [7:0]          own_address_ff;
   logic [7:0]          start_byte_ff;
   logic [7:0]          end_byte_ff;
   logic                crc_enable_ff;

   afr_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          count_ff, count_in;
   logic [7:0]          length_ff, length_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          crc_low_ff, crc_low_in;

   logic                rsp_valid_ff;
   logic                pvalid_ff, pvalid_in;
   logic [7:0]          pbyte_ff, pbyte_in;
   logic [7:0]          pindex_ff, pindex_in;
   logic [7:0]          flen_ff;
   afr_pkg::status_type status_ff, status_in;

   logic                accept;
   logic [7:0]          rx;
   logic [15:0]         crc_step;
   logic [7:0]          count_inc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rx           = req_ch.rx_byte;
   assign count_inc    = count_ff + 8'd1;

   afr_crc16 u_crc (
      .crc      (crc_ff),
      .data     (rx),
      .crc_next (crc_step)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         start_byte_ff  <= '0;
         end_byte_ff    <= '0;
         crc_enable_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            afr_pkg::REG_OWN_ADDRESS: own_address_ff <= csr_wdata[7:0];
            afr_pkg::REG_START_BYTE:  start_byte_ff  <= csr_wdata[7:0];
            afr_pkg::REG_END_BYTE:    end_byte_ff    <= csr_wdata[7:0];
            afr_pkg::REG_CRC_ENABLE:  crc_enable_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // parser step
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      pvalid_in  = 1'b0;
      pbyte_in   = '0;
      pindex_in  = '0;
      status_in  = afr_pkg::ST_BUSY;
      unique case (phase_ff)
         afr_pkg::PH_IDLE: begin
            if (rx == start_byte_ff) phase_in = afr_pkg::PH_ADDR;
         end
         afr_pkg::PH_ADDR: begin
            priority if (rx == own_address_ff) phase_in = afr_pkg::PH_LEN;
            else if (rx != start_byte_ff) phase_in = afr_pkg::PH_IDLE;
            else phase_in = afr_pkg::PH_ADDR;
         end
         afr_pkg::PH_LEN: begin
            if (rx != 8'd0) begin
               count_in  = '0;
               length_in = rx;
               crc_in    = afr_pkg::CRC_INIT;
               phase_in  = afr_pkg::PH_DATA;
            end else begin
               status_in = afr_pkg::ST_ZERO_LEN;
               phase_in  = afr_pkg::PH_IDLE;
            end
         end
         afr_pkg::PH_DATA: begin
            pvalid_in = 1'b1;
            pbyte_in  = rx;
            pindex_in = count_ff;
            crc_in    = crc_step;
            count_in  = count_inc;
            if (count_inc >= length_ff) phase_in = afr_pkg::PH_CRC_LO;
         end
         afr_pkg::PH_CRC_LO: begin
            crc_low_in = rx;
            phase_in   = afr_pkg::PH_CRC_HI;
         end
         afr_pkg::PH_CRC_HI: begin
            if (crc_enable_ff && ({rx, crc_low_ff} != crc_ff)) begin
               status_in = afr_pkg::ST_CRC_ERR;
               phase_in  = afr_pkg::PH_IDLE;
            end else begin
               phase_in = afr_pkg::PH_END;
            end
         end
         afr_pkg::PH_END: begin
            status_in = (rx == end_byte_ff) ? afr_pkg::ST_OK : afr_pkg::ST_BAD_END;
            phase_in  = afr_pkg::PH_IDLE;
         end
         default: begin
            phase_in = afr_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= afr_pkg::PH_IDLE;
         count_ff   <= '0;
         length_ff  <= '0;
         crc_ff     <= afr_pkg::CRC_INIT;
         crc_low_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pvalid_ff <= pvalid_in;
         pbyte_ff  <= pbyte_in;
         pindex_ff <= pindex_in;
         flen_ff   <= length_in;
         status_ff <= status_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.payload_valid = pvalid_ff;
   assign rsp_ch.payload_byte  = pbyte_ff;
   assign rsp_ch.payload_index = pindex_ff;
   assign rsp_ch.frame_length  = flen_ff;
   assign rsp_ch.frame_status  = status_ff;

endmodule

### rtl/core/afr_checker.sv
// afr_checker: port-level checks on the frame receiver, with its bind
// depends on afr_pkg and the top level addressed_frame_receiver_crc16
`timescale 1ns / 1ps

module afr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       payload_valid,
   input logic [7:0] payload_index,
   input logic [7:0] frame_length,
   input logic [2:0] frame_status
);

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // input stalls only behind a pending result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a pending result");

   // payload items never carry a final status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && payload_valid |-> frame_status == afr_pkg::ST_BUSY)
      else $error("payload item with final status");

   // payload index stays inside the announced length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && payload_valid |-> payload_index < frame_length)
      else $error("payload index beyond frame length");

   // every accepted item yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

endmodule

bind addressed_frame_receiver_crc16 afr_checker u_afr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .payload_valid (rsp_ch.payload_valid),
   .payload_index (rsp_ch.payload_index),
   .frame_length  (rsp_ch.frame_length),
   .frame_status  (rsp_ch.frame_status)
);

### tb/testbench.sv
// testbench for addressed_frame_receiver_crc16: directed table, then random frames
// depends on afr_pkg, afr_if (afr_req_if, afr_rsp_if) and the receiver rtl
// results are predicted per accepted byte and checked in order on the rsp channel
`timescale 1ns / 1ps

module testbench;

   localparam int ITEM_TARGET   = 900;
   localparam int CALM_FROM     = 760;
   localparam int PHASE_ITEMS   = 110;
   localparam int HOLD_CYCLES   = 40;
   localparam int STALL_LIMIT   = 400;

   typedef struct packed {
      logic                payload_valid;
      logic [7:0]          payload_byte;
      logic [7:0]          payload_index;
      logic [7:0]          frame_length;
      afr_pkg::status_type frame_status;
   } frame_result_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [afr_pkg::CSR_INDEX_W-1:0]   csr_sel;
      logic [7:0]                        value;
      logic                              typed;
      frame_result_type                  result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [afr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [afr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   afr_req_if req_bus ();
   afr_rsp_if rsp_bus ();

   addressed_frame_receiver_crc16 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // receiver model state and register copy
   afr_pkg::phase_type rx_phase;
   logic [7:0]  rx_count;
   logic [7:0]  rx_length;
   logic [15:0] rx_crc;
   logic [7:0]  crc_low;
   logic [7:0]  my_address;
   logic [7:0]  sof_byte;
   logic [7:0]  eof_byte;
   logic        crc_on;

   frame_result_type pending_frame_results[$];
   frame_result_type next_expected;
   stim_row_type     directed_rows[$];
   int               mismatches;
   int               frame_bytes_sent;
   int               quiet_cycles;
   bit               idle_on;
   bit               rsp_hold_req;

   always #10 clock = ~clock;

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ afr_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic frame_result_type parse_byte(input logic [7:0] b);
      frame_result_type r;
      logic [15:0]      got_crc;
      r.payload_valid = 1'b0;
      r.payload_byte  = 8'h00;
      r.payload_index = 8'h00;
      r.frame_status  = afr_pkg::ST_BUSY;
      case (rx_phase)
         afr_pkg::PH_IDLE: begin
            if (b == sof_byte) rx_phase = afr_pkg::PH_ADDR;
         end
         afr_pkg::PH_ADDR: begin
            if (b == my_address) rx_phase = afr_pkg::PH_LEN;
            else if (b != sof_byte) rx_phase = afr_pkg::PH_IDLE;
         end
         afr_pkg::PH_LEN: begin
            if (b != 8'h00) begin
               rx_count  = 8'h00;
               rx_length = b;
               rx_crc    = afr_pkg::CRC_INIT;
               rx_phase  = afr_pkg::PH_DATA;
            end else begin
               r.frame_status = afr_pkg::ST_ZERO_LEN;
               rx_phase       = afr_pkg::PH_IDLE;
            end
         end
         afr_pkg::PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = rx_count;
            rx_crc          = crc16_next(rx_crc, b);
            rx_count        = rx_count + 8'd1;
            if (rx_count >= rx_length) rx_phase = afr_pkg::PH_CRC_LO;
         end
         afr_pkg::PH_CRC_LO: begin
            crc_low  = b;
            rx_phase = afr_pkg::PH_CRC_HI;
         end
         afr_pkg::PH_CRC_HI: begin
            got_crc = {b, crc_low};
            if (crc_on && got_crc != rx_crc) begin
               r.frame_status = afr_pkg::ST_CRC_ERR;
               rx_phase       = afr_pkg::PH_IDLE;
            end else begin
               rx_phase = afr_pkg::PH_END;
            end
         end
         afr_pkg::PH_END: begin
            r.frame_status = (b == eof_byte) ? afr_pkg::ST_OK : afr_pkg::ST_BAD_END;
            rx_phase       = afr_pkg::PH_IDLE;
         end
         default: rx_phase = afr_pkg::PH_IDLE;
      endcase
      r.frame_length = rx_length;
      return r;
   endfunction

   function automatic stim_row_type row_byte(input logic [7:0] b);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_BYTE;
      row.value   = b;
      return row;
   endfunction

   function automatic stim_row_type row_fixed(input logic [7:0] b, input logic pv,
                                              input logic [7:0] pb, input logic [7:0] pi,
                                              input logic [7:0] fl,
                                              input afr_pkg::status_type st);
      stim_row_type row;
      row        = row_byte(b);
      row.typed  = 1'b1;
      row.result = '{pv, pb, pi, fl, st};
      return row;
   endfunction

   function automatic stim_row_type row_csr(input logic [afr_pkg::CSR_INDEX_W-1:0] sel,
                                            input logic [7:0] v);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.csr_sel = sel;
      row.value   = v;
      return row;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input frame_result_type fixed_result);
      frame_result_type predicted;
      if (csr_we) csr_we <= 1'b0;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = parse_byte(b);
      pending_frame_results.push_back(typed ? fixed_result : predicted);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      if (csr_we) csr_we <= 1'b0;
      while (pending_frame_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [afr_pkg::CSR_INDEX_W-1:0] sel,
                            input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= v;
      @(posedge clock);
      case (sel)
         afr_pkg::REG_OWN_ADDRESS: my_address = v;
         afr_pkg::REG_START_BYTE:  sof_byte   = v;
         afr_pkg::REG_END_BYTE:    eof_byte   = v;
         afr_pkg::REG_CRC_ENABLE:  crc_on     = v[0];
         default: ;
      endcase
   endtask

   // frame with random content, possibly malformed; a nonzero length gives a clean frame
   task automatic send_frame(input int fixed_len);
      logic [7:0]  frame_data[$];
      logic [15:0] crc;
      logic [7:0]  len;
      logic [7:0]  b;
      bit          clean;
      int          extra;
      int          i;
      clean = (fixed_len != 0);
      crc   = afr_pkg::CRC_INIT;
      extra = clean ? 0 : $urandom_range(0, 2);
      repeat (extra + 1) frame_data.push_back(sof_byte);
      frame_data.push_back((clean || $urandom_range(0, 9) != 0) ? my_address : 8'($urandom));
      if (clean) len = 8'(fixed_len);
      else if ($urandom_range(0, 19) == 0) len = 8'h00;
      else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(1, 40));
      else len = 8'($urandom_range(1, 8));
      frame_data.push_back(len);
      for (i = 0; i < int'(len); i++) begin
         b   = 8'($urandom);
         crc = crc16_next(crc, b);
         frame_data.push_back(b);
      end
      if (!clean && $urandom_range(0, 6) == 0) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      frame_data.push_back(crc[7:0]);
      frame_data.push_back(crc[15:8]);
      frame_data.push_back((clean || $urandom_range(0, 6) != 0) ? eof_byte : 8'($urandom));
      foreach (frame_data[k]) begin
         send_byte(frame_data[k], 1'b0, '0);
         frame_bytes_sent++;
      end
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_frame_results.size() == 0) begin
            $error("result item with no expectation pending");
            mismatches++;
         end else begin
            next_expected = pending_frame_results.pop_front();
            check_field("payload_valid", 8'(next_expected.payload_valid),
                        8'(rsp_bus.payload_valid));
            check_field("payload_byte", next_expected.payload_byte, rsp_bus.payload_byte);
            check_field("payload_index", next_expected.payload_index, rsp_bus.payload_index);
            check_field("frame_length", next_expected.frame_length, rsp_bus.frame_length);
            check_field("frame_status", 8'(next_expected.frame_status),
                        8'(rsp_bus.frame_status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int phase_no;
      int phase_end;
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = 8'h00;
      rsp_bus.ready    = 1'b1;
      csr_we           = 1'b0;
      csr_index        = afr_pkg::REG_OWN_ADDRESS;
      csr_wdata        = 8'h00;
      rx_phase         = afr_pkg::PH_IDLE;
      rx_count         = 8'h00;
      rx_length        = 8'h00;
      rx_crc           = afr_pkg::CRC_INIT;
      crc_low          = 8'h00;
      my_address       = 8'h00;
      sof_byte         = 8'h00;
      eof_byte         = 8'h00;
      crc_on           = 1'b1;
      mismatches       = 0;
      frame_bytes_sent = 0;
      quiet_cycles     = 0;
      idle_on          = 1'b1;
      rsp_hold_req     = 1'b0;

      directed_rows = '{
         // reset registers: address compare wins over repeated start, then zero length
         row_fixed(8'h00, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         row_fixed(8'h00, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         row_fixed(8'h00, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_ZERO_LEN),
         row_csr(afr_pkg::REG_OWN_ADDRESS, 8'hFF),
         row_csr(afr_pkg::REG_START_BYTE, 8'h7E),
         row_csr(afr_pkg::REG_END_BYTE, 8'h00),
         row_csr(afr_pkg::REG_CRC_ENABLE, 8'h01),
         // repeated start, then wrong address
         row_fixed(8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         row_fixed(8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         row_fixed(8'h12, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         // good frame, payload ff, crc ff00
         row_fixed(8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         row_fixed(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, afr_pkg::ST_BUSY),
         row_fixed(8'h01, 1'b0, 8'h00, 8'h00, 8'h01, afr_pkg::ST_BUSY),
         row_fixed(8'hFF, 1'b1, 8'hFF, 8'h00, 8'h01, afr_pkg::ST_BUSY),
         row_fixed(8'h00, 1'b0, 8'h00, 8'h00, 8'h01, afr_pkg::ST_BUSY),
         row_fixed(8'hFF, 1'b0, 8'h00, 8'h00, 8'h01, afr_pkg::ST_BUSY),
         row_fixed(8'h00, 1'b0, 8'h00, 8'h00, 8'h01, afr_pkg::ST_OK),
         // crc mismatch
         row_byte(8'h7E),
         row_byte(8'hFF),
         row_byte(8'h01),
         row_fixed(8'h00, 1'b1, 8'h00, 8'h00, 8'h01, afr_pkg::ST_BUSY),
         row_byte(8'h00),
         row_fixed(8'h00, 1'b0, 8'h00, 8'h00, 8'h01, afr_pkg::ST_CRC_ERR),
         // crc check off through a wide value, write past the last register ignored
         row_csr(afr_pkg::REG_CRC_ENABLE, 8'hFE),
         row_csr(3'(afr_pkg::REG_CRC_ENABLE + 1), 8'h01),
         row_csr(afr_pkg::REG_END_BYTE, 8'hFF),
         // wrong crc passes, bad end byte
         row_byte(8'h7E),
         row_byte(8'hFF),
         row_byte(8'h01),
         row_byte(8'hAB),
         row_byte(8'h12),
         row_byte(8'h34),
         row_fixed(8'h55, 1'b0, 8'h00, 8'h00, 8'h01, afr_pkg::ST_BAD_END)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_CSR) begin
            drain_results();
            csr_write(directed_rows[n].csr_sel, directed_rows[n].value);
         end else begin
            send_byte(directed_rows[n].value, directed_rows[n].typed,
                      directed_rows[n].result);
         end
      end

      phase_no = 0;
      while (frame_bytes_sent < ITEM_TARGET) begin
         drain_results();
         idle_on = (phase_no % 3 != 1) && (frame_bytes_sent < CALM_FROM);
         case (phase_no)
            1: begin
               csr_write(afr_pkg::REG_OWN_ADDRESS, 8'h00);
               csr_write(afr_pkg::REG_START_BYTE, 8'hFF);
               csr_write(afr_pkg::REG_END_BYTE, 8'h00);
               csr_write(afr_pkg::REG_CRC_ENABLE, 8'h00);
            end
            2: begin
               csr_write(afr_pkg::REG_OWN_ADDRESS, 8'hFF);
               csr_write(afr_pkg::REG_START_BYTE, 8'h00);
               csr_write(afr_pkg::REG_END_BYTE, 8'hFF);
               csr_write(afr_pkg::REG_CRC_ENABLE, 8'h01);
            end
            default: begin
               csr_write(afr_pkg::REG_OWN_ADDRESS, 8'($urandom));
               csr_write(afr_pkg::REG_START_BYTE, 8'($urandom));
               csr_write(afr_pkg::REG_END_BYTE, 8'($urandom));
               csr_write(afr_pkg::REG_CRC_ENABLE,
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01);
               if ($urandom_range(0, 1) == 0)
                  csr_write(3'(afr_pkg::REG_CRC_ENABLE + $urandom_range(1, 4)),
                            8'($urandom));
            end
         endcase
         if (phase_no == 2) rsp_hold_req = 1'b1;
         if (phase_no == 3) send_frame(255);
         phase_end = frame_bytes_sent + PHASE_ITEMS;
         while (frame_bytes_sent < phase_end && frame_bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, '0);
            end else begin
               send_frame(0);
            end
         end
         phase_no++;
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/core/afr_pkg.sv
rtl/core/afr_if.sv
rtl/core/afr_crc16.sv
rtl/core/addressed_frame_receiver_crc16.sv
rtl/core/afr_checker.sv
tb/testbench.sv
